// ===== design/lhm_pkg.sv =====
// Shared command codes, beat layouts and constants for the latency histogram monitor
`timescale 1ns / 1ps

package lhm_pkg;

  // command codes carried on s_tuser
  localparam logic [1:0] CMD_TASK  = 2'd0;
  localparam logic [1:0] CMD_STEAL = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam int USER_W = 2;
  localparam int IN_W   = 136;
  localparam int OUT_W  = 296;

  // percent scale, the divisor of the percentile target
  localparam logic [7:0] PCT_DIV = 8'd100;

  // input beat, first field in the highest bits
  typedef struct packed {
    logic [6:0]  percent;
    logic        steal_ok;
    logic [63:0] end_time;
    logic [63:0] start_time;
  } in_t;

  // output beat, first field in the highest bits, padded to whole bytes
  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  bucket_hit;
    logic [63:0] percentile_bound;
    logic [31:0] steal_wins;
    logic [31:0] steal_tries;
    logic [63:0] duration_peak;
    logic [63:0] duration_total;
    logic [31:0] task_total;
  } out_t;

endpackage

// ===== design/latency_histogram_monitor.sv =====
// Latency histogram monitor: task and steal counters, log2 histogram, percentile walk
// Steal, clear and a query on an empty store go straight to the result load; a task record
//   steps through subtract, sum, max and bucket read, bucket write, then load.
// A query steps through a product state, then per bucket walked a memory read, an add on the
//   shared 64-bit adder and a scaled compare against the product, then the load.
// One command at a time; the next beat is taken the cycle after the result register loads.
// Reset (rst, synchronous) clears all counters and the bucket valid bits at once.
`timescale 1ns / 1ps

module latency_histogram_monitor #(
  parameter int BUCKETS     = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // start_time[63:0], end_time[127:64], steal_ok[128], percent[135:129]
  input  logic [lhm_pkg::IN_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [lhm_pkg::USER_W-1:0] s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // task_total[31:0], duration_total[95:32], duration_peak[159:96], steal_tries[191:160],
  // steal_wins[223:192], percentile_bound[287:224], bucket_hit[293:288], zero[295:294]
  output logic [lhm_pkg::OUT_W-1:0] m_tdata
);

  import lhm_pkg::*;

  localparam int CW  = COUNT_WIDTH;
  localparam int BW  = $clog2(BUCKETS);
  localparam int QW  = COUNT_WIDTH + 7;
  localparam int SW  = QW + 1;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_MAX  = 4'd3;
  localparam logic [3:0] S_INC  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_WCMP = 4'd6;
  localparam logic [3:0] S_WRD  = 4'd7;
  localparam logic [3:0] S_WACC = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  function automatic logic [3:0] bitlen8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < 8; j++) begin
      if (v[j]) n = 4'(j + 1);
    end
    return n;
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  logic [3:0]    state;
  in_t           in_beat;
  out_t          out_q;

  logic [63:0]   start_time;
  logic [63:0]   end_time;
  logic [6:0]    pct;
  logic [63:0]   dur;
  logic [3:0]    byte_len [8];
  logic [BW-1:0] bucket;

  logic [CW-1:0] task_count;
  logic [63:0]   duration_sum;
  logic [63:0]   duration_max;
  logic [CW-1:0] steal_tries;
  logic [CW-1:0] steal_wins;

  logic [BUCKETS-1:0] bvalid;
  logic [CW-1:0] mem [BUCKETS];
  logic [CW-1:0] rd_data;
  logic [BW-1:0] rd_addr;
  logic [BW-1:0] rd_addr_q;
  logic [CW-1:0] entry;

  logic [QW-1:0] prod;
  logic [QW-1:0] prod_q;
  logic [SW-1:0] cum_scaled;

  logic [BW-1:0] idx;
  logic [CW-1:0] cum;
  logic          cum_hit;
  logic [63:0]   bound;
  logic [5:0]    hit;

  logic [63:0]   add_a;
  logic [63:0]   add_b;
  logic          add_cin;
  logic [64:0]   add_res;
  logic [CW:0]   add_cnt;
  logic [CW-1:0] cnt_sat;

  logic [6:0]    len_c;
  logic [BW-1:0] bucket_c;

  assign in_beat  = in_t'(s_tdata);
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_q;

  // shared 64-bit adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      S_SUB: begin
        add_a   = end_time;
        add_b   = ~start_time;
        add_cin = 1'b1;
      end
      S_LEN: begin
        add_a = duration_sum;
        add_b = dur;
      end
      S_MAX: begin
        add_a   = dur;
        add_b   = ~duration_max;
        add_cin = 1'b1;
      end
      S_INC: begin
        add_a = 64'(entry);
        add_b = 64'(1);
      end
      S_WACC: begin
        add_a = 64'(cum);
        add_b = 64'(entry);
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_res = 65'(add_a) + 65'(add_b) + 65'(add_cin);
  assign add_cnt = add_res[CW:0];
  assign cnt_sat = (add_cnt >= {1'b0, CNT_MAX}) ? CNT_MAX : add_cnt[CW-1:0];

  // bit length from the per-byte lengths, clamped to the last bucket
  always_comb begin
    len_c = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte_len[k] != '0) len_c = 7'(8 * k) + 7'(byte_len[k]);
    end
    bucket_c = (len_c > 7'(BUCKETS - 1)) ? LAST_BKT : len_c[BW-1:0];
  end

  // bucket entry, never-written entries read as zero
  assign entry   = bvalid[rd_addr_q] ? rd_data : '0;
  assign rd_addr = (state == S_MAX) ? bucket_c : idx;

  // count times percent, compared against the running sum plus one, scaled by 100
  assign prod       = QW'(task_count) * QW'(pct);
  assign cum_scaled = SW'(cum) * SW'(PCT_DIV) + SW'(PCT_DIV);

  // running sum reaches max(1, floor(prod / 100)): cum >= 1 and 100 * (cum + 1) > prod
  assign cum_hit = (cum != '0) && (cum_scaled > SW'(prod_q));

  // bucket memory
  always_ff @(posedge clk) begin
    if (state == S_INC) mem[bucket] <= cnt_sat;
    rd_data   <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      task_count   <= '0;
      duration_sum <= '0;
      duration_max <= '0;
      steal_tries  <= '0;
      steal_wins   <= '0;
      bvalid       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            start_time <= in_beat.start_time;
            end_time   <= in_beat.end_time;
            pct        <= in_beat.percent;
            bound      <= '0;
            hit        <= '0;
            case (s_tuser)
              CMD_TASK: begin
                state <= S_SUB;
              end
              CMD_STEAL: begin
                steal_tries <= sat_inc(steal_tries);
                if (in_beat.steal_ok) steal_wins <= sat_inc(steal_wins);
                state <= S_DONE;
              end
              CMD_QUERY: begin
                state <= (task_count == '0) ? S_DONE : S_MUL;
              end
              default: begin
                task_count   <= '0;
                duration_sum <= '0;
                duration_max <= '0;
                steal_tries  <= '0;
                steal_wins   <= '0;
                bvalid       <= '0;
                state        <= S_DONE;
              end
            endcase
          end
        end
        S_SUB: begin
          dur   <= add_res[63:0];
          state <= S_LEN;
        end
        S_LEN: begin
          duration_sum <= add_res[63:0];
          for (int k = 0; k < 8; k++) begin
            byte_len[k] <= bitlen8(dur[8*k +: 8]);
          end
          state <= S_MAX;
        end
        S_MAX: begin
          if (add_res[64]) duration_max <= dur;
          bucket     <= bucket_c;
          task_count <= sat_inc(task_count);
          state      <= S_INC;
        end
        S_INC: begin
          bvalid[bucket] <= 1'b1;
          hit            <= 6'(bucket);
          state          <= S_DONE;
        end
        S_MUL: begin
          prod_q <= prod;
          idx    <= '0;
          cum    <= '0;
          state  <= S_WRD;
        end
        S_WRD: begin
          state <= S_WACC;
        end
        S_WACC: begin
          cum   <= cnt_sat;
          state <= S_WCMP;
        end
        S_WCMP: begin
          if (cum_hit) begin
            bound <= (idx == '0) ? 64'(0) : (64'(1) << idx);
            state <= S_DONE;
          end else if (idx == LAST_BKT) begin
            bound <= 64'(1) << (BUCKETS - 1);
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_WRD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_q.pad              <= '0;
            out_q.bucket_hit       <= hit;
            out_q.percentile_bound <= bound;
            out_q.steal_wins       <= 32'(steal_wins);
            out_q.steal_tries      <= 32'(steal_tries);
            out_q.duration_peak    <= duration_max;
            out_q.duration_total   <= duration_sum;
            out_q.task_total       <= 32'(task_count);
            m_tvalid               <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lhm_checker.sv =====
// Port-level checks for the latency histogram monitor and their bind
`timescale 1ns / 1ps

module lhm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lhm_pkg::OUT_W-1:0]  m_tdata
);

  import lhm_pkg::*;

  out_t o;
  assign o = out_t'(m_tdata);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // the block is not ready again in the cycle after it takes a command
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // a query answer is zero or a single power of two
  a_bound_pow2: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(o.percentile_bound))
    else $error("percentile bound not a power of two");

  // a beat never carries both a bucket hit and a query answer
  a_hit_or_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o.bucket_hit == '0) || (o.percentile_bound == '0))
    else $error("bucket hit and percentile bound both set");

endmodule

bind latency_histogram_monitor lhm_checker u_lhm_checker (.*);

// ===== test/latency_histogram_monitor_tb.sv =====
// Self-checking testbench for the latency histogram monitor: directed table, then random beats
`timescale 1ns / 1ps

module latency_histogram_monitor_tb;
  import lhm_pkg::*;

  localparam int          BINS       = 32;
  localparam logic [31:0] CNT_TOP    = 32'hFFFF_FFFF;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};
  localparam int          RAND_BEATS = 1650;
  localparam int          CALM_TAIL  = 150;
  localparam int          DRAIN_WAIT = 150;
  localparam int          LONG_HOLD  = 400;
  localparam int          MAX_SHOWN  = 10;

  // one row of the directed table
  typedef struct {
    logic [1:0] cmd;
    in_t        beat;
    bit         typed;
    out_t       want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // start_time[63:0], end_time[127:64], steal_ok[128], percent[135:129]
  logic [IN_W-1:0]  s_tdata;
  // cmd[1:0]
  logic [USER_W-1:0] s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  // task_total, duration_total, duration_peak, steal_tries, steal_wins,
  // percentile_bound, bucket_hit, zero pad
  logic [OUT_W-1:0] m_tdata;

  // predictor state
  logic [31:0] tasks_seen;
  logic [63:0] lat_sum;
  logic [63:0] lat_max;
  logic [31:0] steals_tried;
  logic [31:0] steals_won;
  logic [31:0] hist [BINS];

  out_t      pending_snaps [$];
  stim_row_t dir_tab [$];
  int        mismatches   = 0;
  int        results_seen = 0;
  bit        calm         = 1'b0;

  latency_histogram_monitor #(
    .BUCKETS    (BINS),
    .COUNT_WIDTH(32)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == CNT_TOP) ? v : v + 32'd1;
  endfunction

  // running sum of the percentile walk, pinned at the counter top
  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    if (a >= CNT_TOP || b >= CNT_TOP - a) return {32'd0, CNT_TOP};
    return a + b;
  endfunction

  function automatic int bit_len(logic [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic void clear_monitor();
    tasks_seen   = '0;
    lat_sum      = '0;
    lat_max      = '0;
    steals_tried = '0;
    steals_won   = '0;
    for (int i = 0; i < BINS; i++) hist[i] = '0;
  endfunction

  // cumulative walk over the log2 buckets
  function automatic logic [63:0] pct_bound(logic [6:0] pct);
    logic [63:0] cnt;
    logic [63:0] goal;
    logic [63:0] run;
    cnt = {32'd0, tasks_seen};
    if (cnt == 0) return 64'd0;
    goal = (cnt / 64'd100) * pct + ((cnt % 64'd100) * pct) / 64'd100;
    if (goal == 0) goal = 64'd1;
    run = '0;
    for (int i = 0; i < BINS; i++) begin
      run = sat_add(run, {32'd0, hist[i]});
      if (run >= goal) return (i == 0) ? 64'd0 : (64'd1 << i);
    end
    return 64'd1 << (BINS - 1);
  endfunction

  // apply one command to the predictor and return the snapshot it yields
  function automatic out_t advance_monitor(logic [1:0] cmd, in_t beat);
    out_t        snap_o;
    logic [63:0] dur;
    int          b;
    snap_o = '0;
    case (cmd)
      CMD_TASK: begin
        dur = beat.end_time - beat.start_time;
        b = bit_len(dur);
        if (b > BINS - 1) b = BINS - 1;
        tasks_seen = sat_inc(tasks_seen);
        lat_sum = lat_sum + dur;
        if (dur > lat_max) lat_max = dur;
        hist[b] = sat_inc(hist[b]);
        snap_o.bucket_hit = b[5:0];
      end
      CMD_STEAL: begin
        steals_tried = sat_inc(steals_tried);
        if (beat.steal_ok) steals_won = sat_inc(steals_won);
      end
      CMD_QUERY: snap_o.percentile_bound = pct_bound(beat.percent);
      default: clear_monitor();
    endcase
    snap_o.task_total     = tasks_seen;
    snap_o.duration_total = lat_sum;
    snap_o.duration_peak  = lat_max;
    snap_o.steal_tries    = steals_tried;
    snap_o.steal_wins     = steals_won;
    return snap_o;
  endfunction

  function automatic out_t snap(logic [31:0] tasks, logic [63:0] sum, logic [63:0] peak,
                                logic [31:0] tries, logic [31:0] wins, logic [63:0] bound,
                                logic [5:0] hit);
    out_t s;
    s = '0;
    s.task_total       = tasks;
    s.duration_total   = sum;
    s.duration_peak    = peak;
    s.steal_tries      = tries;
    s.steal_wins       = wins;
    s.percentile_bound = bound;
    s.bucket_hit       = hit;
    return s;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] cmd, logic [63:0] t0, logic [63:0] t1,
                                       logic ok, logic [6:0] pct, bit typed, out_t want);
    stim_row_t r;
    r.cmd             = cmd;
    r.beat.start_time = t0;
    r.beat.end_time   = t1;
    r.beat.steal_ok   = ok;
    r.beat.percent    = pct;
    r.typed           = typed;
    r.want            = want;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // durations spread over all bit lengths, short ones favored
  function automatic logic [63:0] pick_duration();
    int          len;
    logic [63:0] mask;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 34);
    if (len == 0) return 64'd0;
    mask = (len == 64) ? ALL_ONES : ((64'd1 << len) - 64'd1);
    return (rand64() & mask) | (64'd1 << (len - 1));
  endfunction

  task automatic cmp_field(input string nm, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch on %s at %0t: expected %h, actual %h", nm, $realtime, want, got);
    end
  endtask

  // drive one beat, wait for the handshake, then record what it should yield
  task automatic offer_beat(input logic [1:0] cmd, input in_t beat, input bit typed,
                            input out_t want);
    out_t guess;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    guess = advance_monitor(cmd, beat);
    pending_snaps.push_back(typed ? want : guess);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // result side: check every beat, random back-pressure, one long hold-off
  initial begin
    out_t want;
    out_t got;
    int   stall_left;
    bit   held_long;
    stall_left = 0;
    held_long  = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_snaps.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result beat at %0t: %h", $realtime, got);
        end else begin
          want = pending_snaps.pop_front();
          cmp_field("task_total", want.task_total, got.task_total);
          cmp_field("duration_total", want.duration_total, got.duration_total);
          cmp_field("duration_peak", want.duration_peak, got.duration_peak);
          cmp_field("steal_tries", want.steal_tries, got.steal_tries);
          cmp_field("steal_wins", want.steal_wins, got.steal_wins);
          cmp_field("percentile_bound", want.percentile_bound, got.percentile_bound);
          cmp_field("bucket_hit", want.bucket_hit, got.bucket_hit);
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!held_long && results_seen >= 300) begin
        stall_left = LONG_HOLD;
        held_long  = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      m_tready <= (stall_left == 0);
    end
  end

  // reset, directed table, random beats, drain and verdict
  initial begin
    in_t  beat;
    out_t none;
    logic [1:0] cmd;
    int   r;
    none = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_TASK;
    clear_monitor();

    // empty store, steal counters, zero duration, wrap-around and clamp
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 50, 1, snap(0, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(mk_row(CMD_STEAL, 0, 0, 0, 0, 1, snap(0, 0, 0, 1, 0, 0, 0)));
    dir_tab.push_back(mk_row(CMD_STEAL, 0, 0, 1, 0, 1, snap(0, 0, 0, 2, 1, 0, 0)));
    dir_tab.push_back(mk_row(CMD_TASK, 0, 0, 0, 0, 1, snap(1, 0, 0, 2, 1, 0, 0)));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 100, 1, snap(1, 0, 0, 2, 1, 0, 0)));
    dir_tab.push_back(mk_row(CMD_TASK, 5, 4, 0, 0, 1,
                             snap(2, ALL_ONES, ALL_ONES, 2, 1, 0, 31)));
    dir_tab.push_back(mk_row(CMD_TASK, 0, 1, 0, 0, 1, snap(3, 0, ALL_ONES, 2, 1, 0, 1)));
    dir_tab.push_back(mk_row(CMD_TASK, ALL_ONES, 0, 1, 127, 0, none));
    dir_tab.push_back(mk_row(CMD_TASK, 0, 64'd1 << 30, 0, 0, 0, none));
    dir_tab.push_back(mk_row(CMD_TASK, 100, 100 + (64'd1 << 30) - 1, 0, 0, 0, none));
    dir_tab.push_back(mk_row(CMD_TASK, 0, 64'd1 << 31, 0, 0, 0, none));
    // percent at zero, above 100 (target past every bucket), mid values
    dir_tab.push_back(mk_row(CMD_QUERY, ALL_ONES, ALL_ONES, 1, 0, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 127, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 101, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 50, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 64, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 1, 0, none));
    dir_tab.push_back(mk_row(CMD_STEAL, ALL_ONES, ALL_ONES, 1, 127, 0, none));
    // clear, then the store is empty again
    dir_tab.push_back(mk_row(CMD_CLEAR, ALL_ONES, ALL_ONES, 1, 127, 1,
                             snap(0, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 100, 1, snap(0, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(mk_row(CMD_TASK, 64'd1 << 63, ALL_ONES, 0, 0, 0, none));
    dir_tab.push_back(mk_row(CMD_QUERY, 0, 0, 0, 100, 0, none));
    dir_tab.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 1, snap(0, 0, 0, 0, 0, 0, 0)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer_beat(dir_tab[i].cmd, dir_tab[i].beat, dir_tab[i].typed,
                                    dir_tab[i].want);

    // random traffic, mostly records, some steals and queries and the odd clear
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n >= RAND_BEATS - CALM_TAIL) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 56)      cmd = CMD_TASK;
      else if (r < 76) cmd = CMD_STEAL;
      else if (r < 96) cmd = CMD_QUERY;
      else             cmd = CMD_CLEAR;
      beat.start_time = rand64();
      beat.end_time   = ($urandom_range(0, 4) == 0) ? rand64()
                                                    : beat.start_time + pick_duration();
      beat.steal_ok   = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       beat.percent = 7'd0;
        1:       beat.percent = 7'd100;
        2:       beat.percent = 7'($urandom_range(101, 127));
        default: beat.percent = 7'($urandom_range(0, 100));
      endcase
      offer_beat(cmd, beat, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_snaps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
